[sv/assert_macros.svh]
// Assertion macros shared by the checker RTL.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[sv/srpc_pkg.sv]
// Package for the safe relative path checker: state structs and byte constants.
// Used by srpc_utf8, srpc_comp and the top level; depends on nothing.
`default_nettype none

package srpc_pkg;

    localparam logic [15:0] MAX_PATH_RESET = 16'd1024;
    localparam logic [15:0] COUNT_MAX      = 16'hffff;

    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COLON  = 8'h3a;

    localparam logic [20:0] CP_MAX      = 21'h10ffff;
    localparam logic [20:0] CP_SURR_LO  = 21'h00d800;
    localparam logic [20:0] CP_SURR_HI  = 21'h00dfff;
    localparam logic [20:0] CP_CTRL_LO  = 21'h00007f;
    localparam logic [20:0] CP_CTRL_HI  = 21'h00009f;
    localparam logic [20:0] CP_MIN_TWO  = 21'h000080;
    localparam logic [20:0] CP_MIN_THR  = 21'h000800;
    localparam logic [20:0] CP_MIN_FOUR = 21'h010000;

    typedef struct packed {
        logic [1:0]  pending;
        logic [1:0]  length;
        logic [20:0] acc;
    } utf8_state_t;

    typedef struct packed {
        logic [15:0] length;
        logic [7:0]  last_byte;
        logic [39:0] stem;
        logic [2:0]  stem_len;
        logic        closed;
    } comp_state_t;

endpackage

`default_nettype wire

[sv/srpc_utf8.sv]
// UTF-8 sequence decoder: next decoder state and reject flag for one byte.
// Depends on srpc_pkg.
`default_nettype none

module srpc_utf8 (
    input  wire logic [7:0]          byte_in,
    input  wire srpc_pkg::utf8_state_t cur,
    output srpc_pkg::utf8_state_t    nxt,
    output logic                     fail
);
    import srpc_pkg::*;

    logic [20:0] acc_shift;
    logic [20:0] minimum;

    assign acc_shift = {cur.acc[14:0], byte_in[5:0]};

    always_comb
    begin
        case (cur.length)
            2'd1:    minimum = CP_MIN_TWO;
            2'd2:    minimum = CP_MIN_THR;
            default: minimum = CP_MIN_FOUR;
        endcase
    end

    always_comb
    begin
        nxt  = cur;
        fail = 1'b0;
        if (cur.pending == 2'd0)
        begin
            if (!byte_in[7])
            begin
                fail = (byte_in <= 8'h1f) || (byte_in == 8'h7f);
            end
            else if (byte_in[7:5] == 3'b110)
            begin
                nxt.length  = 2'd1;
                nxt.pending = 2'd1;
                nxt.acc     = {16'd0, byte_in[4:0]};
            end
            else if (byte_in[7:4] == 4'b1110)
            begin
                nxt.length  = 2'd2;
                nxt.pending = 2'd2;
                nxt.acc     = {17'd0, byte_in[3:0]};
            end
            else if (byte_in[7:3] == 5'b11110)
            begin
                nxt.length  = 2'd3;
                nxt.pending = 2'd3;
                nxt.acc     = {18'd0, byte_in[2:0]};
            end
            else
            begin
                fail = 1'b1;
            end
        end
        else if (byte_in[7:6] != 2'b10)
        begin
            fail        = 1'b1;
            nxt.pending = 2'd0;
        end
        else
        begin
            nxt.acc     = acc_shift;
            nxt.pending = cur.pending - 2'd1;
            if (nxt.pending == 2'd0)
            begin
                fail = (acc_shift < minimum) || (acc_shift > CP_MAX) ||
                       ((acc_shift >= CP_SURR_LO) && (acc_shift <= CP_SURR_HI)) ||
                       ((acc_shift >= CP_CTRL_LO) && (acc_shift <= CP_CTRL_HI));
            end
        end
    end

endmodule

`default_nettype wire

[sv/srpc_comp.sv]
// Path component checker: tracks length, last byte and device-name stem.
// Depends on srpc_pkg.
`default_nettype none

module srpc_comp (
    input  wire logic [7:0]          byte_in,
    input  wire logic                is_last,
    input  wire srpc_pkg::comp_state_t cur,
    output srpc_pkg::comp_state_t    nxt,
    output logic                     fail
);
    import srpc_pkg::*;

    function automatic logic reserved_stem(input logic [39:0] s, input logic [2:0] len);
        logic dev;
        logic three;
        dev   = (s[23:0] == {"M", "O", "C"}) || (s[23:0] == {"T", "P", "L"});
        three = (s[23:0] == {"N", "O", "C"}) || (s[23:0] == {"N", "R", "P"}) ||
                (s[23:0] == {"X", "U", "A"}) || (s[23:0] == {"L", "U", "N"});
        case (len)
            3'd3:    reserved_stem = three;
            3'd4:    reserved_stem = dev && (s[31:24] >= "1") && (s[31:24] <= "9");
            3'd5:    reserved_stem = dev && (s[31:24] == 8'hc2) &&
                                     ((s[39:32] == 8'hb9) || (s[39:32] == 8'hb2) ||
                                      (s[39:32] == 8'hb3));
            default: reserved_stem = 1'b0;
        endcase
    endfunction

    function automatic logic end_bad(input comp_state_t c);
        end_bad = (c.length == 16'd0) || (c.last_byte == CH_SPACE) ||
                  (c.last_byte == CH_DOT) || reserved_stem(c.stem, c.stem_len);
    endfunction

    logic [7:0] upper;

    assign upper = ((byte_in >= "a") && (byte_in <= "z")) ? byte_in - 8'd32 : byte_in;

    always_comb
    begin
        nxt  = cur;
        fail = 1'b0;
        if (byte_in == CH_SLASH)
        begin
            fail = end_bad(cur);
            nxt  = '0;
        end
        else
        begin
            if (cur.length != COUNT_MAX)
            begin
                nxt.length = cur.length + 16'd1;
            end
            nxt.last_byte = byte_in;
            if (!cur.closed)
            begin
                if (byte_in == CH_DOT)
                begin
                    nxt.closed = 1'b1;
                end
                else if (cur.stem_len < 3'd5)
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        if (cur.stem_len == 3'(i))
                        begin
                            nxt.stem[8*i +: 8] = upper;
                        end
                    end
                    nxt.stem_len = cur.stem_len + 3'd1;
                end
                else
                begin
                    nxt.stem_len = 3'd6;
                end
            end
        end
        if (is_last && end_bad(nxt))
        begin
            fail = 1'b1;
        end
    end

endmodule

`default_nettype wire

[sv/safe_relative_path_checker.sv]
// Top level of the safe relative path checker: input register, path state, verdict register.
// Depends on srpc_pkg, srpc_utf8, srpc_comp and assert_macros.svh.
//
// The block takes one path byte per cycle and gives one verdict, in bit 0 of m_axis_tdata,
// for the byte marked by s_axis_tlast; a 1 means the path passed every check. Each byte
// is checked while it sits in the input register; the verdict is registered as the last
// byte leaves that register. A new byte is accepted in every cycle; only a held verdict
// together with a waiting last byte stalls the input. The user must write max_path_bytes
// via cfg_valid/cfg_ready/cfg_data only while no path is open; the block does not enforce it.
`default_nettype none
`include "assert_macros.svh"

module safe_relative_path_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,       // max_path_bytes
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] path_byte
    input  wire logic        s_axis_tlast,   // is_last
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata    // [0] path_valid, [7:1] zero
);
    import srpc_pkg::*;

    logic [15:0]  max_reg;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         in_last_reg;
    logic         out_valid_reg;
    logic         out_data_reg;
    logic         failed_reg;
    logic         failed_next;
    logic [15:0]  byte_count_reg;
    logic [15:0]  byte_count_next;
    logic         first_letter_reg;
    logic         first_letter_next;
    utf8_state_t  utf8_reg;
    utf8_state_t  utf8_next;
    comp_state_t  comp_reg;
    comp_state_t  comp_next;
    logic         utf8_fail;
    logic         comp_fail;
    logic         advance;
    logic         letter;
    logic         illegal;
    logic         verdict_blocked;
    logic         path_end;
    logic         count_step;

    srpc_utf8 u_utf8 (
        .byte_in (in_byte_reg),
        .cur     (utf8_reg),
        .nxt     (utf8_next),
        .fail    (utf8_fail)
    );

    srpc_comp u_comp (
        .byte_in (in_byte_reg),
        .is_last (in_last_reg),
        .cur     (comp_reg),
        .nxt     (comp_next),
        .fail    (comp_fail)
    );

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_data_reg};

    assign verdict_blocked = in_valid_reg && in_last_reg && out_valid_reg && !m_axis_tready;
    assign path_end        = advance && in_last_reg;
    assign count_step      = advance && !in_last_reg && (byte_count_reg != COUNT_MAX);

    assign letter  = ((in_byte_reg >= "A") && (in_byte_reg <= "Z")) ||
                     ((in_byte_reg >= "a") && (in_byte_reg <= "z"));
    assign illegal = in_byte_reg inside {8'h3c, 8'h3e, 8'h3a, 8'h22, 8'h7c, 8'h3f, 8'h2a};

    always_comb
    begin
        failed_next       = failed_reg || utf8_fail || comp_fail || illegal ||
                            (in_byte_reg == CH_BSLASH) || (byte_count_reg >= max_reg);
        first_letter_next = first_letter_reg;
        if (byte_count_reg == 16'd0)
        begin
            first_letter_next = letter;
            if (in_byte_reg == CH_SLASH)
            begin
                failed_next = 1'b1;
            end
        end
        else if ((byte_count_reg == 16'd1) && first_letter_reg && (in_byte_reg == CH_COLON))
        begin
            failed_next = 1'b1;
        end
        if (in_last_reg && (utf8_next.pending != 2'd0))
        begin
            failed_next = 1'b1;
        end
        byte_count_next = (byte_count_reg != COUNT_MAX) ? byte_count_reg + 16'd1
                                                        : byte_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg <= MAX_PATH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            max_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failed_reg       <= 1'b0;
            byte_count_reg   <= 16'd0;
            first_letter_reg <= 1'b0;
            utf8_reg         <= '0;
            comp_reg         <= '0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                failed_reg       <= 1'b0;
                byte_count_reg   <= 16'd0;
                first_letter_reg <= 1'b0;
                utf8_reg         <= '0;
                comp_reg         <= '0;
            end
            else
            begin
                failed_reg       <= failed_next;
                byte_count_reg   <= byte_count_next;
                first_letter_reg <= first_letter_next;
                utf8_reg         <= utf8_next;
                comp_reg         <= comp_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_data_reg <= !failed_next;
        end
    end

    `ASSERT_SAME(a_stall_last, verdict_blocked, !s_axis_tready)
    `ASSERT_NEXT(a_clear_after_verdict, path_end, byte_count_reg == 16'd0 && !failed_reg)
    `ASSERT_NEXT(a_count_step, count_step, byte_count_reg == $past(byte_count_reg) + 16'd1)
    `ASSERT_NEXT(a_failed_sticky, advance && !in_last_reg && failed_reg, failed_reg)

endmodule

`default_nettype wire
